// ===== sv/prqs_pkg.sv =====
// Package for the priority ready queue scheduler.
// Holds the fixed field widths, the item codes, the engine state type and the result word.
// No dependencies.
`timescale 1ns / 1ps

package prqs_pkg;

  localparam int ID_W       = 4;
  localparam int ID_SPACE   = 16;
  localparam int PRIO_OUT_W = 8;
  localparam int COUNT_W    = 5;

  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_SWITCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } prqs_state_e;

  typedef struct packed {
    logic                  running_valid;
    logic [ID_W-1:0]       running_task;
    logic [PRIO_OUT_W-1:0] running_priority;
    logic [COUNT_W-1:0]    ready_count;
    logic                  error;
  } prqs_result_t;

endpackage

// ===== sv/priority_ready_queue_scheduler.sv =====
// Top level of the priority ready queue scheduler: engine plus output word register.
// Depends on prqs_pkg and prqs_engine.
`timescale 1ns / 1ps

// A create word's result is handed from the finish state to the output register, and the
// engine goes back to idle once the register has taken it. A switch word with n candidates
// (queued tasks plus the running task when it is re-queued) takes longest when the winner
// is the first candidate and shortest when it is the last: the queue memory's single read
// port walks all n entries once to find the first task with the smallest priority, and
// then walks the entries behind the winner once more to close the gap. A switch with
// nothing to run finishes like a create. A result that cannot enter a full output register
// holds the engine until it can. The queue and priority memories need no clearing after
// reset. A new word is taken as soon as the engine is idle, even while the last result
// still waits in the output register.
module priority_ready_queue_scheduler #(
  parameter int MAX_TASKS     = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [3:0] task_id_i,
  input  logic [7:0] priority_req_i,
  input  logic       current_ready_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       running_valid_o,
  output logic [3:0] running_task_o,
  output logic [7:0] running_priority_o,
  output logic [4:0] ready_count_o,
  output logic       error_o
);

  import prqs_pkg::*;

  logic         res_valid;
  logic         res_ready;
  prqs_result_t res;
  prqs_result_t out_q;
  logic         out_valid_q, out_valid_d;

  prqs_engine #(
    .MAX_TASKS     (MAX_TASKS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .task_id_i       (task_id_i),
    .priority_req_i  (priority_req_i),
    .current_ready_i (current_ready_i),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign running_valid_o    = out_q.running_valid;
  assign running_task_o     = out_q.running_task;
  assign running_priority_o = out_q.running_priority;
  assign ready_count_o      = out_q.ready_count;
  assign error_o            = out_q.error;

  // An idle engine never holds a finished result.
  a_idle_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res_valid)
    else $error("engine is idle while a result is pending");

  // A result handed over lands in the output register.
  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_o)
    else $error("result was lost at the output register");

  // With nothing running the task and priority words read as zero.
  a_idle_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !running_valid_o) |-> (running_task_o == '0 && running_priority_o == '0))
    else $error("no running task but nonzero task or priority");

endmodule

// ===== sv/prqs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the ready queue and the per-task priority table.
`timescale 1ns / 1ps

module prqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/prqs_engine.sv =====
// Scheduling engine: sequencer over the ready queue and priority memories.
// Depends on prqs_pkg and instantiates two prqs_ram memories.
`timescale 1ns / 1ps

module prqs_engine #(
  parameter int MAX_TASKS     = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             kind_i,
  input  logic [prqs_pkg::ID_W-1:0]        task_id_i,
  input  logic [7:0]                       priority_req_i,
  input  logic                             current_ready_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output prqs_pkg::prqs_result_t           res_o
);

  import prqs_pkg::*;

  localparam int IdxW  = $clog2(MAX_TASKS + 1);
  localparam int CntW  = $clog2(MAX_TASKS + 2);
  localparam int AddrW = $clog2(MAX_TASKS);
  localparam int PrioW = PRIORITY_BITS;
  localparam logic [IdxW-1:0] MaxLen = IdxW'(MAX_TASKS);

  prqs_state_e state_q, state_d;
  logic [IdxW-1:0]  len_q, len_d;
  logic [ID_W-1:0]  run_id_q, run_id_d;
  logic             run_valid_q, run_valid_d;
  logic [PrioW-1:0] run_prio_q, run_prio_d;
  logic             err_q, err_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  best_idx_q, best_idx_d;
  logic [ID_W-1:0]  best_id_q, best_id_d;
  logic [PrioW-1:0] best_prio_q, best_prio_d;
  logic             have_best_q, have_best_d;
  logic             s1_vld_q, s1_vld_d;
  logic [CntW-1:0]  s1_idx_q, s1_idx_d;
  logic             s1_virt_q, s1_virt_d;
  logic             s2_vld_q, s2_vld_d;
  logic [CntW-1:0]  s2_idx_q, s2_idx_d;
  logic [ID_W-1:0]  s2_id_q, s2_id_d;
  logic             sh_vld_q, sh_vld_d;
  logic [CntW-1:0]  sh_idx_q, sh_idx_d;
  logic             sh_virt_q, sh_virt_d;

  logic             ord_we;
  logic [AddrW-1:0] ord_waddr;
  logic [ID_W-1:0]  ord_wdata;
  logic [AddrW-1:0] ord_raddr;
  logic [ID_W-1:0]  ord_rdata;
  logic             pr_we;
  logic [ID_W-1:0]  pr_waddr;
  logic [PrioW-1:0] pr_wdata;
  logic [ID_W-1:0]  pr_raddr;
  logic [PrioW-1:0] pr_rdata;

  logic [PrioW+7:0] prio_in_ext;
  logic [PrioW-1:0] prio_in;
  logic [PrioW+7:0] prio_out_ext;
  logic [IdxW+4:0]  len_out_ext;
  logic [CntW-1:0]  len_ext;
  logic [CntW-1:0]  n_m1;
  logic [CntW-1:0]  sh_idx_m1;
  logic [ID_W-1:0]  s1_id;
  logic             requeue;

  assign prio_in_ext  = {{PrioW{1'b0}}, priority_req_i};
  assign prio_in      = prio_in_ext[PrioW-1:0];
  assign prio_out_ext = {8'b0, run_prio_q};
  assign len_out_ext  = {5'b0, len_q};
  assign len_ext      = CntW'(len_q);
  assign n_m1         = n_q - CntW'(1);
  assign sh_idx_m1    = sh_idx_q - CntW'(1);
  assign s1_id        = s1_virt_q ? run_id_q : ord_rdata;
  assign requeue      = run_valid_q && current_ready_i;

  prqs_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_TASKS)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  prqs_ram #(
    .WIDTH (PrioW),
    .DEPTH (ID_SPACE)
  ) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (pr_waddr),
    .wdata_i (pr_wdata),
    .raddr_i (pr_raddr),
    .rdata_o (pr_rdata)
  );

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    run_id_d    = run_id_q;
    run_valid_d = run_valid_q;
    run_prio_d  = run_prio_q;
    err_d       = err_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    best_idx_d  = best_idx_q;
    best_id_d   = best_id_q;
    best_prio_d = best_prio_q;
    have_best_d = have_best_q;
    s1_vld_d    = 1'b0;
    s1_idx_d    = s1_idx_q;
    s1_virt_d   = s1_virt_q;
    s2_vld_d    = 1'b0;
    s2_idx_d    = s2_idx_q;
    s2_id_d     = s2_id_q;
    sh_vld_d    = 1'b0;
    sh_idx_d    = sh_idx_q;
    sh_virt_d   = sh_virt_q;
    ord_we      = 1'b0;
    ord_waddr   = sh_idx_m1[AddrW-1:0];
    ord_wdata   = sh_virt_q ? run_id_q : ord_rdata;
    ord_raddr   = cnt_q[AddrW-1:0];
    pr_we       = 1'b0;
    pr_waddr    = task_id_i;
    pr_wdata    = prio_in;
    pr_raddr    = s1_id;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    if (s1_vld_q) begin
      s2_vld_d = 1'b1;
      s2_idx_d = s1_idx_q;
      s2_id_d  = s1_id;
    end
    if (s2_vld_q && (!have_best_q || (pr_rdata < best_prio_q))) begin
      have_best_d = 1'b1;
      best_idx_d  = s2_idx_q;
      best_id_d   = s2_id_q;
      best_prio_d = pr_rdata;
    end
    if (sh_vld_q) begin
      ord_we = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_FINISH;
          if (kind_i == KIND_CREATE) begin
            if (len_q == MaxLen) begin
              err_d = 1'b1;
            end else begin
              err_d     = 1'b0;
              ord_we    = 1'b1;
              ord_waddr = len_q[AddrW-1:0];
              ord_wdata = task_id_i;
              pr_we     = 1'b1;
              len_d     = len_q + IdxW'(1);
              if (run_valid_q && (task_id_i == run_id_q)) begin
                run_prio_d = prio_in;
              end
            end
          end else begin
            err_d = 1'b0;
            n_d   = len_ext + CntW'(requeue);
            if ((len_q == '0) && !requeue) begin
              run_valid_d = 1'b0;
              run_id_d    = '0;
            end else begin
              cnt_d       = '0;
              have_best_d = 1'b0;
              state_d     = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q != n_q) begin
          s1_vld_d  = 1'b1;
          s1_idx_d  = cnt_q;
          s1_virt_d = (cnt_q == len_ext);
          cnt_d     = cnt_q + CntW'(1);
        end else if (!s1_vld_q && !s2_vld_q) begin
          cnt_d   = best_idx_q + CntW'(1);
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (cnt_q != n_q) begin
          sh_vld_d  = 1'b1;
          sh_idx_d  = cnt_q;
          sh_virt_d = (cnt_q == len_ext);
          cnt_d     = cnt_q + CntW'(1);
        end else if (!sh_vld_q) begin
          len_d       = n_m1[IdxW-1:0];
          run_id_d    = best_id_q;
          run_valid_d = 1'b1;
          run_prio_d  = best_prio_q;
          state_d     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.running_valid    = run_valid_q;
    res_o.running_task     = run_valid_q ? run_id_q : '0;
    res_o.running_priority = run_valid_q ? prio_out_ext[PRIO_OUT_W-1:0] : '0;
    res_o.ready_count      = len_out_ext[COUNT_W-1:0];
    res_o.error            = err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      run_id_q    <= '0;
      run_valid_q <= 1'b0;
      err_q       <= 1'b0;
      have_best_q <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      sh_vld_q    <= 1'b0;
      cnt_q       <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      run_id_q    <= run_id_d;
      run_valid_q <= run_valid_d;
      err_q       <= err_d;
      have_best_q <= have_best_d;
      s1_vld_q    <= s1_vld_d;
      s2_vld_q    <= s2_vld_d;
      sh_vld_q    <= sh_vld_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_prio_q  <= run_prio_d;
    best_idx_q  <= best_idx_d;
    best_id_q   <= best_id_d;
    best_prio_q <= best_prio_d;
    s1_idx_q    <= s1_idx_d;
    s1_virt_q   <= s1_virt_d;
    s2_idx_q    <= s2_idx_d;
    s2_id_q     <= s2_id_d;
    sh_idx_q    <= sh_idx_d;
    sh_virt_q   <= sh_virt_d;
  end

endmodule
